[src/bsws_pkg.sv]
// ----------------------------------------------------------------------------
// bsws_pkg
// Types and codes shared by the bounded stack with search.
// ----------------------------------------------------------------------------
package bsws_pkg;

	localparam logic [1:0] FUNC_PUSH   = 2'd0;
	localparam logic [1:0] FUNC_POP    = 2'd1;
	localparam logic [1:0] FUNC_SEARCH = 2'd2;

	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_FULL     = 3'd1;
	localparam logic [2:0] STAT_EMPTY    = 3'd2;
	localparam logic [2:0] STAT_NOTFOUND = 3'd3;
	localparam logic [2:0] STAT_MATCH    = 3'd4;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] operand_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] popped_value;
		logic [5:0]         match_index;
		logic [6:0]         fill_count;
		logic               last_result;
	} out_item_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic load;
		logic shift;
	} cell_cmd_t;

endpackage

[src/bsws_cell.sv]
// ----------------------------------------------------------------------------
// bsws_cell
// One stack entry: shifts with its neighbors on push and pop, and holds a
// match flag that moves down the row during a search.
// ----------------------------------------------------------------------------
module bsws_cell #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  bsws_pkg::cell_cmd_t cmd,
	input  logic [6:0]          count,
	input  logic signed [31:0]  key,
	input  logic signed [31:0]  up_word,
	input  logic signed [31:0]  dn_word,
	input  logic                flag_in,
	output logic signed [31:0]  word,
	output logic                flag
);
	import bsws_pkg::*;

	logic signed [31:0] word_q;
	logic               flag_q;
	logic               occupied;

	// cell 0 is the top of the stack
	assign occupied = (7'(IDX) < count);

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			word_q <= up_word;
		end else if (cmd.pop) begin
			word_q <= dn_word;
		end
		if (cmd.load) begin
			flag_q <= occupied && (word_q == key);
		end else if (cmd.shift) begin
			flag_q <= flag_in;
		end
	end

	assign word = word_q;
	assign flag = flag_q;

endmodule

[src/bounded_stack_with_search_core.sv]
// ----------------------------------------------------------------------------
// bounded_stack_with_search_core
// Bounded LIFO stack of signed words held in a row of shifting cells, with a
// bottom-first linear search.
// ----------------------------------------------------------------------------
// Push, pop and the unused code give their result on the cycle after the item
// is taken and busy stays low, so an item can follow every cycle. A search
// holds busy high through the SCAN and FLUSH states: all cells compare at
// once, then the match flags shift one cell per cycle toward the bottom of the
// row and are read there, so match results come out during the scan and the
// final one (or not found) in the same cycle that busy falls. Each result is on the
// result port for one cycle with result_valid high; the receiver cannot stall
// it.
// ----------------------------------------------------------------------------
module bounded_stack_with_search_core #(
	parameter int DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  bsws_pkg::in_item_t  request,
	output logic                result_valid,
	output bsws_pkg::out_item_t result
);
	import bsws_pkg::*;

	localparam int SW = $clog2(DEPTH);

	typedef enum logic [2:0] {
		IDLE  = 3'b001,
		SCAN  = 3'b010,
		FLUSH = 3'b100
	} state_t;

	state_t             state_q;
	logic [6:0]         count_q;
	logic [SW-1:0]      step_q;
	logic [6:0]         idx_q;
	logic               pend_v_q;
	logic [5:0]         pend_idx_q;
	logic               res_valid_q;
	out_item_t          res_q;

	cell_cmd_t          cmd;
	logic               accept;
	logic               tail;
	logic signed [31:0] cell_word [DEPTH];
	logic               cell_flag [DEPTH];

	assign busy   = (state_q != IDLE);
	assign accept = start && !busy;
	assign tail   = cell_flag[DEPTH-1];

	always_comb begin
		cmd.push  = accept && (request.func == FUNC_PUSH) && (count_q < 7'(DEPTH));
		cmd.pop   = accept && (request.func == FUNC_POP) && (count_q != 7'd0);
		cmd.load  = accept && (request.func == FUNC_SEARCH);
		cmd.shift = (state_q == SCAN);
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic signed [31:0] up_w;
		logic signed [31:0] dn_w;
		logic               f_in;
		if (k == 0) begin : g_top
			assign up_w = request.operand_value;
			assign f_in = 1'b0;
		end else begin : g_mid
			assign up_w = cell_word[k-1];
			assign f_in = cell_flag[k-1];
		end
		if (k == DEPTH - 1) begin : g_bot
			assign dn_w = '0;
		end else begin : g_above
			assign dn_w = cell_word[k+1];
		end
		bsws_cell #(
			.IDX(k)
		) u_cell (
			.clk    (clk),
			.cmd    (cmd),
			.count  (count_q),
			.key    (request.operand_value),
			.up_word(up_w),
			.dn_word(dn_w),
			.flag_in(f_in),
			.word   (cell_word[k]),
			.flag   (cell_flag[k])
		);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			count_q     <= 7'd0;
			pend_v_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					res_valid_q <= accept && (request.func != FUNC_SEARCH);
					if (accept) begin
						if (request.func == FUNC_SEARCH) begin
							state_q  <= SCAN;
							pend_v_q <= 1'b0;
						end else begin
							if (cmd.push) begin
								count_q <= count_q + 7'd1;
							end else if (cmd.pop) begin
								count_q <= count_q - 7'd1;
							end
						end
					end
				end
				SCAN: begin
					res_valid_q <= tail && pend_v_q;
					if (tail) begin
						pend_v_q <= 1'b1;
					end
					if (step_q == SW'(DEPTH - 1)) begin
						state_q <= FLUSH;
					end
				end
				FLUSH: begin
					res_valid_q <= 1'b1;
					state_q     <= IDLE;
				end
				default: begin
					res_valid_q <= 1'b0;
					state_q     <= IDLE;
				end
			endcase
		end
	end

	// scan position and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			IDLE: begin
				step_q <= '0;
				idx_q  <= count_q - 7'(DEPTH);
				res_q.match_index  <= '0;
				res_q.last_result  <= 1'b1;
				case (request.func)
					FUNC_PUSH: begin
						res_q.status       <= cmd.push ? STAT_OK : STAT_FULL;
						res_q.fill_count   <= cmd.push ? count_q + 7'd1 : count_q;
						res_q.popped_value <= '0;
					end
					FUNC_POP: begin
						res_q.status       <= cmd.pop ? STAT_OK : STAT_EMPTY;
						res_q.fill_count   <= cmd.pop ? count_q - 7'd1 : count_q;
						res_q.popped_value <= cmd.pop ? cell_word[0] : 32'sd0;
					end
					default: begin
						res_q.status       <= STAT_OK;
						res_q.fill_count   <= count_q;
						res_q.popped_value <= '0;
					end
				endcase
			end
			SCAN: begin
				step_q <= step_q + SW'(1);
				idx_q  <= idx_q + 7'd1;
				if (tail) begin
					pend_idx_q <= idx_q[5:0];
				end
				res_q.status       <= STAT_MATCH;
				res_q.popped_value <= '0;
				res_q.match_index  <= pend_idx_q;
				res_q.fill_count   <= count_q;
				res_q.last_result  <= 1'b0;
			end
			FLUSH: begin
				res_q.status       <= pend_v_q ? STAT_MATCH : STAT_NOTFOUND;
				res_q.popped_value <= '0;
				res_q.match_index  <= pend_v_q ? pend_idx_q : 6'd0;
				res_q.fill_count   <= count_q;
				res_q.last_result  <= 1'b1;
			end
			default: begin
				step_q <= '0;
			end
		endcase
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
